>>> src/filter_wheel_serial_responder_assert.svh
`ifndef FILTER_WHEEL_SERIAL_RESPONDER_ASSERT_SVH
`define FILTER_WHEEL_SERIAL_RESPONDER_ASSERT_SVH

// same-cycle implication, reset masked
`define FWSR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fwsr assertion failed");

// next-cycle implication, reset masked
`define FWSR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fwsr assertion failed");

`endif

>>> src/fwsr_pkg.sv
`timescale 1ns / 1ps
package fwsr_pkg;

  localparam logic [7:0] FRAME_HEADER = 8'hA5;
  localparam logic [7:0] CMD_SELECT   = 8'h01;
  localparam logic [7:0] CMD_STATUS   = 8'h02;
  localparam logic [7:0] CMD_HOME     = 8'h03;
  localparam logic [7:0] RSP_SELECT   = 8'h81;
  localparam logic [7:0] RSP_STATUS   = 8'h82;
  localparam logic [7:0] RSP_HOME     = 8'h83;
  localparam logic [7:0] ASCII_ZERO   = 8'h30;
  localparam logic [1:0] LAST_POS     = 2'd3;

  typedef struct packed {
    logic [7:0] cmd;
    logic [7:0] value;
  } rsp_req_t;

  typedef struct packed {
    logic [1:0] pos;
    logic [3:0] current_slot;
    logic [3:0] target_slot;
  } front_stat_t;

endpackage

>>> src/fwsr_intf.sv
`timescale 1ns / 1ps
interface fwsr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface fwsr_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last_of_reply;
  modport source (output valid, output tx_byte, output last_of_reply, input ready);
  modport sink (input valid, input tx_byte, input last_of_reply, output ready);
endinterface

interface fwsr_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] slot_count;
  modport source (output valid, output slot_count, input ready);
  modport sink (input valid, input slot_count, output ready);
endinterface

>>> src/fwsr_front.sv
`timescale 1ns / 1ps
module fwsr_front
  import fwsr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  fwsr_rx_if.sink     rx,
  fwsr_cfg_if.sink    cfg,
  input  logic        room,
  output logic        push,
  output rsp_req_t    push_data,
  output front_stat_t stat
);

  logic [7:0] frame_store [3];
  logic [1:0] pos;
  logic [3:0] current_slot;
  logic [3:0] target_slot;
  logic [3:0] slot_count;

  logic [1:0] pos_next;
  logic [3:0] cur_next;
  logic [3:0] tgt_next;
  logic [3:0] cur_mid;
  logic       accept;
  logic       frame_ok;
  logic [7:0] sum;

  assign cfg.ready = 1'b1;
  assign rx.ready  = (pos != LAST_POS) || room;
  assign accept    = rx.valid && rx.ready;
  assign sum       = frame_store[0] + frame_store[1] + frame_store[2];
  assign frame_ok  = (frame_store[0] == FRAME_HEADER) && (rx.rx_byte == sum);

  assign stat.pos          = pos;
  assign stat.current_slot = current_slot;
  assign stat.target_slot  = target_slot;

  always_comb begin
    pos_next  = pos;
    cur_next  = current_slot;
    tgt_next  = target_slot;
    cur_mid   = current_slot;
    push      = 1'b0;
    push_data = '0;
    if (accept) begin
      if (pos != LAST_POS) begin
        pos_next = pos + 2'd1;
      end else begin
        pos_next = '0;
        if (frame_ok) begin
          unique case (frame_store[1])
            CMD_SELECT: begin
              if ((frame_store[2] >= 8'd1) && (frame_store[2] <= {4'd0, slot_count})) begin
                tgt_next = frame_store[2][3:0];
              end
              push = 1'b1;
              push_data.cmd = RSP_SELECT;
              push_data.value = (current_slot == tgt_next) ? {4'd0, tgt_next} : 8'd0;
            end
            CMD_STATUS: begin
              push = 1'b1;
              push_data.cmd = RSP_STATUS;
              push_data.value = (current_slot == target_slot) ?
                                (ASCII_ZERO + {4'd0, current_slot}) : ASCII_ZERO;
            end
            CMD_HOME: begin
              cur_mid  = 4'd1;
              tgt_next = 4'd1;
              push = 1'b1;
              push_data.cmd = RSP_HOME;
              push_data.value = ASCII_ZERO + {4'd0, slot_count};
            end
            default: begin
            end
          endcase
        end
        // one slot toward target after every frame
        priority if (cur_mid < tgt_next) begin
          cur_next = cur_mid + 4'd1;
        end else if (cur_mid > tgt_next) begin
          cur_next = cur_mid - 4'd1;
        end else begin
          cur_next = cur_mid;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= '0;
      current_slot <= 4'd1;
      target_slot  <= 4'd1;
      slot_count   <= 4'd5;
    end else begin
      pos          <= pos_next;
      current_slot <= cur_next;
      target_slot  <= tgt_next;
      if (cfg.valid && cfg.ready) begin
        slot_count <= cfg.slot_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (pos != LAST_POS)) begin
      frame_store[pos] <= rx.rx_byte;
    end
  end

endmodule

>>> src/fwsr_queue.sv
`timescale 1ns / 1ps
module fwsr_queue
  import fwsr_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  rsp_req_t push_data,
  output logic     room,
  input  logic     pop,
  output logic     nonempty,
  output rsp_req_t head
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  rsp_req_t      slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign room     = (count != FULL);
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

>>> src/fwsr_back.sv
`timescale 1ns / 1ps
module fwsr_back
  import fwsr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     nonempty,
  input  rsp_req_t head,
  output logic     pop,
  fwsr_tx_if.source tx
);

  logic       busy;
  logic [1:0] idx;
  logic [7:0] cmd;
  logic [7:0] value;
  logic [7:0] csum;
  logic       done;

  assign done = tx.valid && tx.ready && (idx == LAST_POS);
  assign pop  = nonempty && (!busy || done);

  assign tx.valid         = busy;
  assign tx.last_of_reply = (idx == LAST_POS);

  always_comb begin
    unique case (idx)
      2'd0:    tx.tx_byte = FRAME_HEADER;
      2'd1:    tx.tx_byte = cmd;
      2'd2:    tx.tx_byte = value;
      default: tx.tx_byte = csum;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (done) begin
        busy <= 1'b0;
        idx  <= '0;
      end else if (tx.valid && tx.ready) begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd   <= head.cmd;
      value <= head.value;
      csum  <= FRAME_HEADER + head.cmd + head.value;
    end
  end

endmodule

>>> src/filter_wheel_serial_responder.sv
`timescale 1ns / 1ps
// channel  dir  handshake     payload
// rx       in   valid/ready   rx_byte[7:0]
// tx       out  valid/ready   tx_byte[7:0], last_of_reply
// cfg      in   valid/ready   slot_count[3:0]
//
// rx takes one byte per cycle unless stalled; a good frame's fourth byte
// queues a reply request, which leaves as 4 bytes from the output stage
// rx stalls only on a fourth byte while the request queue is full
// rst is synchronous: position 0, current and target slot 1, slot_count 5
`include "filter_wheel_serial_responder_assert.svh"
module filter_wheel_serial_responder
  import fwsr_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  fwsr_rx_if.sink   rx,
  fwsr_tx_if.source tx,
  fwsr_cfg_if.sink  cfg
);

  logic        q_push;
  rsp_req_t    q_push_data;
  logic        q_room;
  logic        q_pop;
  logic        q_nonempty;
  rsp_req_t    q_head;
  front_stat_t stat;

  fwsr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .cfg       (cfg),
    .room      (q_room),
    .push      (q_push),
    .push_data (q_push_data),
    .stat      (stat)
  );

  fwsr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .room      (q_room),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .head      (q_head)
  );

  fwsr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .nonempty (q_nonempty),
    .head     (q_head),
    .pop      (q_pop),
    .tx       (tx)
  );

  `FWSR_ASSERT_NOW(a_push_has_room, q_push, q_room)
  `FWSR_ASSERT_NOW(a_push_on_last_byte, q_push, rx.valid && rx.ready && (stat.pos == LAST_POS))
  `FWSR_ASSERT_NEXT(a_slot_holds_mid_frame, rx.valid && rx.ready && (stat.pos != LAST_POS), $stable(stat.current_slot) && $stable(stat.target_slot))

endmodule
